FILE: sv/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduction unit.
package rar_pkg;

  // Operation select carried with each input beat.
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_ADD = 2'd0;
  localparam mode_t MODE_SUB = 2'd1;
  localparam mode_t MODE_MUL = 2'd2;
  localparam mode_t MODE_DIV = 2'd3;

  // Result field widths.
  localparam int RES_NUM_W = 64;
  localparam int RES_DEN_W = 63;

  // Operation of the shared adder/subtractor.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Which magnitude product the multiplier is forming.
  typedef enum logic [1:0] {
    PROD_NUM,
    PROD_CROSS,
    PROD_DEN
  } prod_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_COMB,
    ST_COMB2,
    ST_CHECK,
    ST_TWO,
    ST_GCD,
    ST_DIVM,
    ST_DIVD,
    ST_NEG,
    ST_FIN
  } state_t;

endpackage

FILE: sv/rar_addsub.sv
// Shared adder/subtractor used by the multiply, combine, gcd, divide and negate steps.
module rar_addsub #(
  parameter int WIDTH = 65
) (
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  rar_pkg::alu_op_t op,
  output logic [WIDTH-1:0] sum
);

  // Subtraction is addition of the inverted operand with a carry in.
  logic [WIDTH-1:0] b_eff;
  logic             cin;

  always_comb begin
    if (op == rar_pkg::ALU_SUB) begin
      b_eff = ~op_b;
      cin   = 1'b1;
    end else begin
      b_eff = op_b;
      cin   = 1'b0;
    end
  end

  assign sum = op_a + b_eff + WIDTH'(cin);

endmodule

FILE: sv/rational_arithmetic_reduce.sv
// Rational add/subtract/multiply/divide with gcd reduction, built around one shared adder.
// Steps: shift-add products (three for add and subtract, two for multiply and divide), each
// set up in a load step, then the combine, a binary gcd, two restoring divisions by the gcd
// and the sign of the numerator. A zero result skips the gcd and divisions, and error inputs
// go straight to the finish. Items do not overlap: a new beat is taken only in the idle state,
// after the last result has gone to the output register; the single shared adder does the
// arithmetic of every step.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module rational_arithmetic_reduce #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_res_num,
  output logic [62:0]        out_res_den,
  output logic               out_err_zero_den,
  output logic               out_overflow
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int AW = MW + 1;
  localparam int CW = $clog2(MW);

  // Operand slices, signs and magnitudes of the incoming beat.
  logic [W-1:0] an_w, ad_w, bn_w, bd_w;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic         an_s, ad_s, bn_s, bd_s;
  logic         err_in;

  assign an_w = in_a_num[W-1:0];
  assign ad_w = in_a_den[W-1:0];
  assign bn_w = in_b_num[W-1:0];
  assign bd_w = in_b_den[W-1:0];
  assign an_s = an_w[W-1];
  assign ad_s = ad_w[W-1];
  assign bn_s = bn_w[W-1];
  assign bd_s = bd_w[W-1];
  assign an_mag = an_s ? (~an_w + W'(1)) : an_w;
  assign ad_mag = ad_s ? (~ad_w + W'(1)) : ad_w;
  assign bn_mag = bn_s ? (~bn_w + W'(1)) : bn_w;
  assign bd_mag = bd_s ? (~bd_w + W'(1)) : bd_w;
  assign err_in = (ad_w == '0) || (bd_w == '0)
               || ((rar_pkg::mode_t'(in_mode) == rar_pkg::MODE_DIV) && (bn_w == '0));

  // Control registers.
  rar_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Datapath registers.
  rar_pkg::mode_t  mode_r, mode_nxt;
  rar_pkg::prod_t  k_r, k_nxt;
  logic [W-1:0]    an_mag_r, an_mag_nxt, ad_mag_r, ad_mag_nxt;
  logic [W-1:0]    bn_mag_r, bn_mag_nxt, bd_mag_r, bd_mag_nxt;
  logic [W-1:0]    mcand_r, mcand_nxt;
  logic [MW-1:0]   p_r, p_nxt;
  logic [MW-1:0]   m_r, m_nxt, d_r, d_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [MW-1:0]   q_r, q_nxt, rem_r, rem_nxt;
  logic [AW-1:0]   num_r, num_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            n1_r, n1_nxt, n2_r, n2_nxt, dneg_r, dneg_nxt, neg_r, neg_nxt;
  logic            err_r, err_nxt, zero_r, zero_nxt, ovf_r, ovf_nxt;
  logic [63:0]     res_num_r, res_num_nxt;
  logic [62:0]     res_den_r, res_den_nxt;
  logic            res_err_r, res_err_nxt, res_ovf_r, res_ovf_nxt;

  // Shared adder/subtractor.
  logic [AW-1:0]    alu_a, alu_b, alu_y;
  rar_pkg::alu_op_t alu_op;

  rar_addsub #(.WIDTH(AW)) u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .op   (alu_op),
    .sum  (alu_y)
  );

  // Multiplier operand selection for the product being formed.
  logic [W-1:0] mcand_sel, mplr_sel;

  always_comb begin
    case (k_r)
      rar_pkg::PROD_NUM: begin
        mcand_sel = an_mag_r;
        mplr_sel  = (mode_r == rar_pkg::MODE_MUL) ? bn_mag_r : bd_mag_r;
      end
      rar_pkg::PROD_CROSS: begin
        mcand_sel = bn_mag_r;
        mplr_sel  = ad_mag_r;
      end
      rar_pkg::PROD_DEN: begin
        mcand_sel = ad_mag_r;
        mplr_sel  = (mode_r == rar_pkg::MODE_DIV) ? bn_mag_r : bd_mag_r;
      end
      default: begin
        mcand_sel = '0;
        mplr_sel  = '0;
      end
    endcase
  end

  // Restoring division step: shift in the next dividend bit and try the divisor.
  logic [AW-1:0] rem_sh;
  logic [MW-1:0] q_shift;
  logic          div_fit;

  assign rem_sh  = {rem_r, q_r[MW-1]};
  assign div_fit = ~alu_y[AW-1];
  assign q_shift = {q_r[MW-2:0], div_fit};

  // Overflow test of the unreduced numerator against the signed 64-bit range.
  logic [MW+63:0] m_ext;
  logic           m_hi_nz, ovf_calc;

  assign m_ext    = {64'b0, m_r};
  assign m_hi_nz  = |m_ext[MW+63:64];
  assign ovf_calc = m_hi_nz | (m_ext[63] & (~neg_r | (|m_ext[62:0])));

  // Result field extension.
  logic [AW+63:0] num_ext;
  logic [MW+62:0] den_ext;

  assign num_ext = {{64{num_r[AW-1]}}, num_r};
  assign den_ext = {63'b0, d_r};

  logic out_free;
  assign out_free = ~out_valid_r | ~out_stall;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rar_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = err_in ? rar_pkg::ST_FIN : rar_pkg::ST_LOAD;
        end
      end
      rar_pkg::ST_LOAD: begin
        state_nxt = rar_pkg::ST_MUL;
      end
      rar_pkg::ST_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = (k_r == rar_pkg::PROD_DEN) ? rar_pkg::ST_COMB : rar_pkg::ST_LOAD;
        end
      end
      rar_pkg::ST_COMB: begin
        if ((mode_r == rar_pkg::MODE_ADD || mode_r == rar_pkg::MODE_SUB)
            && (n1_r != n2_r) && alu_y[AW-1]) begin
          state_nxt = rar_pkg::ST_COMB2;
        end else begin
          state_nxt = rar_pkg::ST_CHECK;
        end
      end
      rar_pkg::ST_COMB2: begin
        state_nxt = rar_pkg::ST_CHECK;
      end
      rar_pkg::ST_CHECK: begin
        state_nxt = (m_r == '0) ? rar_pkg::ST_FIN : rar_pkg::ST_TWO;
      end
      rar_pkg::ST_TWO: begin
        if (x_r[0] | y_r[0]) begin
          state_nxt = rar_pkg::ST_GCD;
        end
      end
      rar_pkg::ST_GCD: begin
        if (y_r == '0) begin
          state_nxt = rar_pkg::ST_DIVM;
        end
      end
      rar_pkg::ST_DIVM: begin
        if (cnt_r == '0) begin
          state_nxt = rar_pkg::ST_DIVD;
        end
      end
      rar_pkg::ST_DIVD: begin
        if (cnt_r == '0) begin
          state_nxt = rar_pkg::ST_NEG;
        end
      end
      rar_pkg::ST_NEG: begin
        state_nxt = rar_pkg::ST_FIN;
      end
      rar_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = rar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rar_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output control for each state.
  always_comb begin
    mode_nxt      = mode_r;
    k_nxt         = k_r;
    an_mag_nxt    = an_mag_r;
    ad_mag_nxt    = ad_mag_r;
    bn_mag_nxt    = bn_mag_r;
    bd_mag_nxt    = bd_mag_r;
    mcand_nxt     = mcand_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    cnt_nxt       = cnt_r;
    n1_nxt        = n1_r;
    n2_nxt        = n2_r;
    dneg_nxt      = dneg_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    zero_nxt      = zero_r;
    ovf_nxt       = ovf_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    res_err_nxt   = res_err_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r & out_stall;
    alu_a         = '0;
    alu_b         = '0;
    alu_op        = rar_pkg::ALU_ADD;

    case (state_r)
      // Capture magnitudes and signs of the new beat.
      rar_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = rar_pkg::mode_t'(in_mode);
          an_mag_nxt = an_mag;
          ad_mag_nxt = ad_mag;
          bn_mag_nxt = bn_mag;
          bd_mag_nxt = bd_mag;
          n1_nxt     = an_s ^ ((rar_pkg::mode_t'(in_mode) == rar_pkg::MODE_MUL) ? bn_s : bd_s);
          n2_nxt     = bn_s ^ ad_s ^ (rar_pkg::mode_t'(in_mode) == rar_pkg::MODE_SUB);
          dneg_nxt   = ad_s ^ ((rar_pkg::mode_t'(in_mode) == rar_pkg::MODE_DIV) ? bn_s : bd_s);
          err_nxt    = err_in;
          zero_nxt   = 1'b0;
          k_nxt      = rar_pkg::PROD_NUM;
        end
      end
      // Set up one shift-add multiplication.
      rar_pkg::ST_LOAD: begin
        p_nxt     = {{W{1'b0}}, mplr_sel};
        mcand_nxt = mcand_sel;
        cnt_nxt   = CW'(W - 1);
      end
      // One multiplier bit: conditional add into the upper half, then shift right.
      rar_pkg::ST_MUL: begin
        alu_a = AW'(p_r[MW-1:W]);
        alu_b = p_r[0] ? AW'(mcand_r) : '0;
        p_nxt = {alu_y[W:0], p_r[W-1:1]};
        if (cnt_r == '0) begin
          case (k_r)
            rar_pkg::PROD_NUM: begin
              m_nxt = p_nxt;
              k_nxt = (mode_r == rar_pkg::MODE_ADD || mode_r == rar_pkg::MODE_SUB)
                    ? rar_pkg::PROD_CROSS : rar_pkg::PROD_DEN;
            end
            rar_pkg::PROD_CROSS: begin
              x_nxt = p_nxt;
              k_nxt = rar_pkg::PROD_DEN;
            end
            rar_pkg::PROD_DEN: begin
              d_nxt = p_nxt;
            end
            default: begin
              d_nxt = p_nxt;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      // Combine the two cross products by their signs (add and subtract), or just fix the result sign.
      rar_pkg::ST_COMB: begin
        alu_a = AW'(m_r);
        alu_b = AW'(x_r);
        if (mode_r == rar_pkg::MODE_ADD || mode_r == rar_pkg::MODE_SUB) begin
          alu_op = (n1_r == n2_r) ? rar_pkg::ALU_ADD : rar_pkg::ALU_SUB;
          if ((n1_r == n2_r) || !alu_y[AW-1]) begin
            m_nxt   = alu_y[MW-1:0];
            neg_nxt = n1_r ^ dneg_r;
          end
        end else begin
          neg_nxt = n1_r ^ dneg_r;
        end
      end
      // Second cross product was the larger one.
      rar_pkg::ST_COMB2: begin
        alu_a   = AW'(x_r);
        alu_b   = AW'(m_r);
        alu_op  = rar_pkg::ALU_SUB;
        m_nxt   = alu_y[MW-1:0];
        neg_nxt = n2_r ^ dneg_r;
      end
      // Zero result, or start the gcd on copies of numerator and denominator.
      rar_pkg::ST_CHECK: begin
        if (m_r == '0) begin
          zero_nxt = 1'b1;
        end else begin
          ovf_nxt = ovf_calc;
          x_nxt   = m_r;
          y_nxt   = d_r;
        end
      end
      // Remove common factors of two from the gcd pair and from the result.
      rar_pkg::ST_TWO: begin
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          m_nxt = m_r >> 1;
          d_nxt = d_r >> 1;
        end
      end
      // Binary gcd step; x ends as the odd part of the gcd.
      rar_pkg::ST_GCD: begin
        alu_a  = AW'(y_r);
        alu_b  = AW'(x_r);
        alu_op = rar_pkg::ALU_SUB;
        if (y_r == '0) begin
          q_nxt   = m_r;
          rem_nxt = '0;
          cnt_nxt = CW'(MW - 1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (alu_y[AW-1]) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          y_nxt = alu_y[MW-1:0];
        end
      end
      // Exact division of the numerator by the gcd.
      rar_pkg::ST_DIVM: begin
        alu_a   = rem_sh;
        alu_b   = AW'(x_r);
        alu_op  = rar_pkg::ALU_SUB;
        rem_nxt = div_fit ? alu_y[MW-1:0] : rem_sh[MW-1:0];
        q_nxt   = q_shift;
        if (cnt_r == '0) begin
          m_nxt   = q_shift;
          q_nxt   = d_r;
          rem_nxt = '0;
          cnt_nxt = CW'(MW - 1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      // Exact division of the denominator by the gcd.
      rar_pkg::ST_DIVD: begin
        alu_a   = rem_sh;
        alu_b   = AW'(x_r);
        alu_op  = rar_pkg::ALU_SUB;
        rem_nxt = div_fit ? alu_y[MW-1:0] : rem_sh[MW-1:0];
        q_nxt   = q_shift;
        if (cnt_r == '0) begin
          d_nxt = q_shift;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      // Apply the sign to the reduced numerator.
      rar_pkg::ST_NEG: begin
        alu_a   = '0;
        alu_b   = AW'(m_r);
        alu_op  = neg_r ? rar_pkg::ALU_SUB : rar_pkg::ALU_ADD;
        num_nxt = alu_y;
      end
      // Hand the result to the output register once it is free.
      rar_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            res_num_nxt = '0;
            res_den_nxt = '0;
            res_err_nxt = 1'b1;
            res_ovf_nxt = 1'b0;
          end else if (zero_r) begin
            res_num_nxt = '0;
            res_den_nxt = 63'd1;
            res_err_nxt = 1'b0;
            res_ovf_nxt = 1'b0;
          end else begin
            res_num_nxt = num_ext[63:0];
            res_den_nxt = den_ext[62:0];
            res_err_nxt = 1'b0;
            res_ovf_nxt = ovf_r;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r & out_stall;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rar_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    k_r       <= k_nxt;
    an_mag_r  <= an_mag_nxt;
    ad_mag_r  <= ad_mag_nxt;
    bn_mag_r  <= bn_mag_nxt;
    bd_mag_r  <= bd_mag_nxt;
    mcand_r   <= mcand_nxt;
    p_r       <= p_nxt;
    m_r       <= m_nxt;
    d_r       <= d_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    num_r     <= num_nxt;
    cnt_r     <= cnt_nxt;
    n1_r      <= n1_nxt;
    n2_r      <= n2_nxt;
    dneg_r    <= dneg_nxt;
    neg_r     <= neg_nxt;
    err_r     <= err_nxt;
    zero_r    <= zero_nxt;
    ovf_r     <= ovf_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    res_err_r <= res_err_nxt;
    res_ovf_r <= res_ovf_nxt;
  end

  assign in_stall         = (state_r != rar_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_res_num      = res_num_r;
  assign out_res_den      = res_den_r;
  assign out_err_zero_den = res_err_r;
  assign out_overflow     = res_ovf_r;

  // An error beat carries an all-zero fraction and no overflow.
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err_zero_den |-> out_res_num == '0 && out_res_den == '0 && !out_overflow)
    else $error("error beat carries a nonzero result");

  // A good result always has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_err_zero_den |-> out_res_den != '0)
    else $error("result denominator is zero");

  // During the binary gcd at least one operand stays odd.
  a_gcd_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rar_pkg::ST_GCD |-> (x_r[0] || y_r[0]))
    else $error("gcd operands both even");

  // A finished item reaches the output register when it is free.
  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rar_pkg::ST_FIN && !out_valid_r |=> out_valid_r)
    else $error("finished item not delivered");

endmodule

FILE: tb/tb_rational_arithmetic_reduce.sv
// Self-checking testbench for the rational add/subtract/multiply/divide unit with gcd reduction.
module tb_rational_arithmetic_reduce;

  localparam int unsigned WATCHDOG_CYCLES = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned RANDOM_ITEMS = 750;

  localparam logic signed [31:0] OPND_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] OPND_MAX = 32'sh7FFF_FFFF;

  // One reduced fraction as it leaves the block.
  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               err_zero_den;
    logic               overflow;
  } ratio_t;

  // Works out the reduced fraction for each accepted operand beat and checks result beats
  // against it in order.
  class ratio_scoreboard;
    ratio_t expected_q[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function longint unsigned magnitude(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function ratio_t reduce_ratio(rar_pkg::mode_t mode, logic signed [31:0] an_in,
                                  logic signed [31:0] ad_in, logic signed [31:0] bn_in,
                                  logic signed [31:0] bd_in);
      longint            an, ad, bn, bd;
      longint unsigned   m, m1, m2, d, x, y, t;
      bit                neg, dneg, n1, n2, ovf;
      ratio_t            r;
      an = an_in;
      ad = ad_in;
      bn = bn_in;
      bd = bd_in;
      r = '0;
      // A zero denominator anywhere, or dividing by a zero fraction, gives the error beat.
      if (ad == 0 || bd == 0 || (mode == rar_pkg::MODE_DIV && bn == 0)) begin
        r.err_zero_den = 1'b1;
        return r;
      end
      // Sign and magnitude of the unreduced numerator and denominator.
      case (mode)
        rar_pkg::MODE_ADD, rar_pkg::MODE_SUB: begin
          m1 = magnitude(an) * magnitude(bd);
          m2 = magnitude(bn) * magnitude(ad);
          n1 = (an < 0) != (bd < 0);
          n2 = (bn < 0) != (ad < 0);
          if (mode == rar_pkg::MODE_SUB) n2 = !n2;
          if (m2 == 0) n2 = 1'b0;
          if (m1 == 0) n1 = 1'b0;
          if (n1 == n2) begin
            m = m1 + m2;
            neg = n1;
          end else if (m1 >= m2) begin
            m = m1 - m2;
            neg = n1;
          end else begin
            m = m2 - m1;
            neg = n2;
          end
          d = magnitude(ad) * magnitude(bd);
          dneg = (ad < 0) != (bd < 0);
        end
        rar_pkg::MODE_MUL: begin
          m = magnitude(an) * magnitude(bn);
          neg = (an < 0) != (bn < 0);
          d = magnitude(ad) * magnitude(bd);
          dneg = (ad < 0) != (bd < 0);
        end
        default: begin
          m = magnitude(an) * magnitude(bd);
          neg = (an < 0) != (bd < 0);
          d = magnitude(ad) * magnitude(bn);
          dneg = (ad < 0) != (bn < 0);
        end
      endcase
      neg = neg != dneg;
      // Zero always comes out as 0/1.
      if (m == 0) begin
        r.den = 63'd1;
        return r;
      end
      ovf = neg ? (m > 64'h8000_0000_0000_0000) : (m > 64'h7FFF_FFFF_FFFF_FFFF);
      // Euclid on the magnitudes, then divide both out.
      x = m;
      y = d;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      m = m / x;
      d = d / x;
      r.num = neg ? -m : m;
      r.den = d[62:0];
      r.overflow = ovf;
      return r;
    endfunction

    function void note_input(rar_pkg::mode_t mode, logic signed [31:0] an,
                             logic signed [31:0] ad, logic signed [31:0] bn,
                             logic signed [31:0] bd);
      expected_q.push_back(reduce_ratio(mode, an, ad, bn, bd));
    endfunction

    function void check_result(ratio_t got);
      ratio_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: num %0d den %0d err %0b ovf %0b",
                 $time, got.num, got.den, got.err_zero_den, got.overflow);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.num !== want.num) begin
        $display("%0t: res_num expected %0d actual %0d", $time, want.num, got.num);
        errors++;
      end
      if (got.den !== want.den) begin
        $display("%0t: res_den expected %0d actual %0d", $time, want.den, got.den);
        errors++;
      end
      if (got.err_zero_den !== want.err_zero_den) begin
        $display("%0t: err_zero_den expected %0b actual %0b", $time, want.err_zero_den,
                 got.err_zero_den);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rar_pkg::mode_t     in_mode;
  logic signed [31:0] in_a_num;
  logic signed [31:0] in_a_den;
  logic signed [31:0] in_b_num;
  logic signed [31:0] in_b_den;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] out_res_num;
  logic [62:0]        out_res_den;
  logic               out_err_zero_den;
  logic               out_overflow;

  ratio_scoreboard sb = new();

  rational_arithmetic_reduce uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_err_zero_den (out_err_zero_den),
    .out_overflow     (out_overflow)
  );

  always #2 clk = ~clk;

  // Idle time before a beat: mostly none or short, now and then long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Operand values: small ones so reduction bites, power-of-two multiples, extremes, or raw bits.
  function automatic logic signed [31:0] pick_operand();
    int                 sel;
    logic signed [31:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = $signed($urandom_range(0, 40)) - 20;
    end else if (sel < 55) begin
      v = $urandom_range(1, 1000) << $urandom_range(0, 20);
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 65) begin
      case ($urandom_range(0, 5))
        0: v = OPND_MIN;
        1: v = OPND_MAX;
        2: v = OPND_MIN + 1;
        3: v = 32'sd1;
        4: v = -32'sd1;
        default: v = 32'sd0;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Present one operand beat and hold it until the block takes it.
  task automatic send_operands(rar_pkg::mode_t mode, logic signed [31:0] an,
                               logic signed [31:0] ad, logic signed [31:0] bn,
                               logic signed [31:0] bd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Note every accepted operand beat.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      sb.note_input(in_mode, in_a_num, in_a_den, in_b_num, in_b_den);
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_result({out_res_num, out_res_den, out_err_zero_den, out_overflow});
    end
  end

  // Result-side back-pressure: free runs of varying length, short stalls, a few long ones.
  initial begin
    int stall_left;
    int run_left;
    int pick;
    out_stall = 1'b0;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        out_stall <= 1'b0;
        pick = $urandom_range(0, 99);
        run_left = (pick < 10) ? $urandom_range(100, 800) : $urandom_range(0, 30);
        pick = $urandom_range(0, 99);
        if (pick < 40) stall_left = 0;
        else if (pick < 92) stall_left = $urandom_range(1, 4);
        else stall_left = $urandom_range(20, 120);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Reset, directed beats, random beats, then drain and report.
  initial begin
    in_valid = 1'b0;
    in_mode  = rar_pkg::MODE_ADD;
    in_a_num = '0;
    in_a_den = '0;
    in_b_num = '0;
    in_b_den = '0;
    rst_n    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Plain cases for each operation, with sign handling in the denominators.
    send_operands(rar_pkg::MODE_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    send_operands(rar_pkg::MODE_SUB, -32'sd3, -32'sd7, 32'sd2, -32'sd5);
    send_operands(rar_pkg::MODE_MUL, -32'sd2, 32'sd4, 32'sd3, -32'sd9);
    send_operands(rar_pkg::MODE_DIV, 32'sd3, 32'sd4, -32'sd6, 32'sd8);
    // Zero denominators and division by a zero fraction.
    send_operands(rar_pkg::MODE_ADD, 32'sd5, 32'sd0, 32'sd1, 32'sd3);
    send_operands(rar_pkg::MODE_MUL, 32'sd5, 32'sd7, 32'sd1, 32'sd0);
    send_operands(rar_pkg::MODE_SUB, 32'sd5, 32'sd0, 32'sd1, 32'sd0);
    send_operands(rar_pkg::MODE_DIV, 32'sd5, 32'sd7, 32'sd0, -32'sd3);
    // Results that are zero.
    send_operands(rar_pkg::MODE_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
    send_operands(rar_pkg::MODE_MUL, 32'sd0, -32'sd5, 32'sd7, 32'sd3);
    send_operands(rar_pkg::MODE_DIV, 32'sd0, 32'sd3, 32'sd5, 32'sd7);
    send_operands(rar_pkg::MODE_ADD, -32'sd1, -32'sd1, 32'sd1, -32'sd1);
    // Extremes, including the one sum that does not fit 64 signed bits.
    send_operands(rar_pkg::MODE_ADD, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
    send_operands(rar_pkg::MODE_MUL, OPND_MIN, OPND_MAX, OPND_MIN, OPND_MAX);
    send_operands(rar_pkg::MODE_DIV, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
    send_operands(rar_pkg::MODE_SUB, OPND_MIN, 32'sd1, OPND_MAX, 32'sd1);
    send_operands(rar_pkg::MODE_ADD, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
    send_operands(rar_pkg::MODE_MUL, -32'sd1, OPND_MIN, -32'sd1, OPND_MIN);
    send_operands(rar_pkg::MODE_DIV, 32'sd1, OPND_MIN, OPND_MAX, -32'sd1);
    send_operands(rar_pkg::MODE_SUB, 32'shAAAA_AAAA, 32'sh5555_5555,
                  32'sh5555_5555, 32'shAAAA_AAAA);
    send_operands(rar_pkg::MODE_ADD, OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN);
    send_operands(rar_pkg::MODE_MUL, OPND_MAX, OPND_MIN, OPND_MAX, OPND_MIN);

    repeat (RANDOM_ITEMS) begin
      send_operands(rar_pkg::mode_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
